FILE: design/xsr_pkg.sv
package xsr_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int VALUE_W     = 64;
  localparam int GEN_W       = 32;
  localparam int RUN_W       = 7;
  localparam int MAX_RUN     = 64;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_DRAW   = 2'd2;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef struct packed {
    logic             start;
    logic [GEN_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic [GEN_W-1:0] xs_step(input logic [GEN_W-1:0] s);
    logic [GEN_W-1:0] a;
    logic [GEN_W-1:0] b;
    a = s ^ (s << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

endpackage

FILE: design/xsr_ram.sv
module xsr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/xsr_divider.sv
module xsr_divider (
  input  logic              clk,
  input  logic              rst,
  input  xsr_pkg::div_req_t req,
  output xsr_pkg::div_rsp_t rsp
);

  logic [xsr_pkg::GEN_W-1:0]         quo;
  logic [xsr_pkg::CNT_W-1:0]         rem;
  logic [xsr_pkg::CNT_W-1:0]         divisor;
  logic [$clog2(xsr_pkg::GEN_W)-1:0] cnt;
  logic                              busy;
  logic                              done;
  logic [xsr_pkg::CNT_W:0]           trial;
  logic [xsr_pkg::CNT_W:0]           diff;
  logic [xsr_pkg::CNT_W-1:0]         rem_next;

  always_comb begin
    trial = {rem, quo[xsr_pkg::GEN_W-1]};
    diff  = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      rem_next = diff[xsr_pkg::CNT_W-1:0];
    end else begin
      rem_next = trial[xsr_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '1)) begin
        busy <= 1'b0;
      end
      done <= !req.start && busy && (cnt == '1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo     <= req.dividend;
      divisor <= req.divisor;
      rem     <= '0;
      cnt     <= '0;
    end else if (busy) begin
      quo <= quo << 1;
      rem <= rem_next;
      cnt <= cnt + 1'b1;
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem;

endmodule

FILE: design/xorshift_resampler.sv
// Resampling with replacement from a table of 64-bit words.
// Input stream (s_*): s_tuser carries the command (clear, append, draw);
// s_tdata carries the value word and the draw count. Clear and append give
// no output word. A draw gives a run of draw_count words (saturated to 64)
// on the output stream (m_*), m_tlast on the final one; m_tuser is the
// status (1 = table empty, one word only). Each drawn word takes one
// generator step, a bit-serial remainder by the entry count, one table
// read and the load of the output register. s_tready is low while a draw
// is in progress.
// The output register lets the next sample be computed while a word waits;
// a stalled receiver holds the sequencer only at the point of loading.
// cfg_* loads the generator seed (zero loads one) and is always ready.
// Reset empties the table, sets the seed to one and drops any pending word.
module xorshift_resampler (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // value[63:0], draw_count[70:64], zero pad[71]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // drawn_value[63:0], drawn_index[75:64], zero pad[79:76]
  output logic        m_tlast,
  output logic [0:0]  m_tuser,   // status[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_STEP  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;
  localparam logic [2:0] ST_EMPTY = 3'd5;

  logic [2:0]                      state;
  logic [xsr_pkg::CNT_W-1:0]       entry_count;
  logic [xsr_pkg::GEN_W-1:0]       gen;
  logic [xsr_pkg::GEN_W-1:0]       gen_next;
  logic [xsr_pkg::RUN_W-1:0]       remaining;
  logic [xsr_pkg::RUN_W-1:0]       run_len;
  logic [xsr_pkg::IDX_W-1:0]       idx;
  logic [xsr_pkg::VALUE_W-1:0]     rd_data;
  xsr_pkg::div_req_t               div_req;
  xsr_pkg::div_rsp_t               div_rsp;
  logic                            in_fire;
  logic                            out_free;
  logic                            app_we;
  logic [1:0]                      cmd;
  logic [xsr_pkg::VALUE_W-1:0]     value;
  logic [xsr_pkg::RUN_W-1:0]       draw_count;

  assign cmd        = s_tuser;
  assign value      = s_tdata[xsr_pkg::VALUE_W-1:0];
  assign draw_count = s_tdata[xsr_pkg::VALUE_W +: xsr_pkg::RUN_W];

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign gen_next  = xsr_pkg::xs_step(gen);
  assign app_we    = in_fire && (cmd == xsr_pkg::CMD_APPEND)
                     && (entry_count < xsr_pkg::CNT_W'(xsr_pkg::TABLE_DEPTH));
  assign run_len   = (draw_count > xsr_pkg::RUN_W'(xsr_pkg::MAX_RUN))
                     ? xsr_pkg::RUN_W'(xsr_pkg::MAX_RUN) : draw_count;

  assign div_req.start    = (state == ST_STEP);
  assign div_req.dividend = gen_next;
  assign div_req.divisor  = entry_count;

  xsr_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  xsr_ram #(
    .WIDTH (xsr_pkg::VALUE_W),
    .DEPTH (xsr_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (app_we),
    .waddr (entry_count[xsr_pkg::IDX_W-1:0]),
    .wdata (value),
    .raddr (idx),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      gen         <= xsr_pkg::GEN_W'(1);
      remaining   <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if ((state == ST_OUT || state == ST_EMPTY) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        gen <= (cfg_data == '0) ? xsr_pkg::GEN_W'(1) : cfg_data;
      end else if (state == ST_STEP) begin
        gen <= gen_next;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            case (cmd)
              xsr_pkg::CMD_CLEAR: begin
                entry_count <= '0;
              end
              xsr_pkg::CMD_APPEND: begin
                if (app_we) begin
                  entry_count <= entry_count + 1'b1;
                end
              end
              xsr_pkg::CMD_DRAW: begin
                if (entry_count == '0) begin
                  state <= ST_EMPTY;
                end else if (run_len != '0) begin
                  remaining <= run_len;
                  state     <= ST_STEP;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_STEP: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            remaining <= remaining - 1'b1;
            state     <= (remaining == xsr_pkg::RUN_W'(1)) ? ST_IDLE : ST_STEP;
          end
        end
        ST_EMPTY: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIV && div_rsp.done) begin
      idx <= div_rsp.remainder[xsr_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_tdata <= {4'b0, idx, rd_data};
      m_tlast <= (remaining == xsr_pkg::RUN_W'(1));
      m_tuser <= xsr_pkg::STATUS_OK;
    end else if (state == ST_EMPTY && out_free) begin
      m_tdata <= '0;
      m_tlast <= 1'b1;
      m_tuser <= xsr_pkg::STATUS_EMPTY;
    end
  end

endmodule

FILE: design/xsr_checker.sv
module xsr_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic        m_tlast,
  input logic [0:0]  m_tuser
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word pending after reset");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> m_tlast)
    else $error("empty status word not marked last");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
    else $error("empty status word carries data");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled output word changed");

endmodule

bind xorshift_resampler xsr_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
